>>> rtl/bao_pkg.sv
`timescale 1ns / 1ps
package bao_pkg;

	localparam int MAX_BLOCKS = 64;
	localparam int IDX_W      = $clog2(MAX_BLOCKS);
	localparam int CNT_W      = 7;
	localparam int OWNER_W    = 8;

	localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_BLOCKS);

	typedef enum logic {
		OP_ALLOC   = 1'b0,
		OP_RELEASE = 1'b1
	} op_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic cnt_step;
		logic restart;
		logic alloc_step;
		logic rel_step;
		logic out_load;
	} bao_ctl_t;

	// Status from the datapath back to the controller.
	typedef struct packed {
		logic scan_end;
		logic is_rel;
		logic go_alloc;
		logic alloc_done;
		logic rel_done;
	} bao_sts_t;

endpackage

>>> rtl/bao_ram.sv
`timescale 1ns / 1ps
module bao_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

>>> rtl/bao_ctrl.sv
`timescale 1ns / 1ps
module bao_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           s_tvalid,
	output logic           s_tready,
	output logic           m_tvalid,
	input  logic           m_tready,
	input  bao_pkg::bao_sts_t sts,
	output bao_pkg::bao_ctl_t ctl
);
	import bao_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_COUNT,
		ST_ALLOC,
		ST_REL,
		ST_FIN
	} state_t;

	state_t state_q;
	logic   m_tvalid_q;

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;

	always_comb begin
		ctl = '0;
		unique case (state_q)
			ST_IDLE:  ctl.load = s_tvalid;
			ST_COUNT: begin
				ctl.cnt_step = !sts.scan_end;
				ctl.restart  = sts.scan_end;
			end
			ST_ALLOC: ctl.alloc_step = 1'b1;
			ST_REL:   ctl.rel_step = 1'b1;
			ST_FIN:   ctl.out_load = !m_tvalid_q || m_tready;
			default:  ctl = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			m_tvalid_q <= 1'b0;
		end else begin
			if (ctl.out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid) state_q <= ST_COUNT;
				end
				ST_COUNT: begin
					if (sts.scan_end) begin
						if (sts.is_rel) begin
							state_q <= ST_REL;
						end else if (sts.go_alloc) begin
							state_q <= ST_ALLOC;
						end else begin
							state_q <= ST_FIN;
						end
					end
				end
				ST_ALLOC: begin
					if (sts.alloc_done) state_q <= ST_FIN;
				end
				ST_REL: begin
					if (sts.rel_done) state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (ctl.out_load) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

>>> rtl/bao_dpath.sv
`timescale 1ns / 1ps
module bao_dpath (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_wr_en,
	input  logic [bao_pkg::CNT_W-1:0]    cfg_wr_data,
	input  logic                         req_op,
	input  logic [bao_pkg::OWNER_W-1:0]  req_owner,
	input  logic [bao_pkg::CNT_W-1:0]    req_count,
	input  bao_pkg::bao_ctl_t            ctl,
	output bao_pkg::bao_sts_t            sts,
	output logic                         res_ok,
	output logic [bao_pkg::CNT_W-1:0]    res_free
);
	import bao_pkg::*;

	logic [CNT_W-1:0]      cap_q;
	logic [CNT_W-1:0]      lim;
	logic                  op_q;
	logic [OWNER_W-1:0]    owner_q;
	logic [CNT_W-1:0]      want_q;
	logic [CNT_W-1:0]      idx_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [CNT_W-1:0]      rem_q;
	logic                  ok_q;
	logic [MAX_BLOCKS-1:0] free_q;
	logic                  rd_vld_s1;
	logic [IDX_W-1:0]      rd_idx_s1;
	logic                  res_ok_q;
	logic [CNT_W-1:0]      res_free_q;
	logic                  in_rng;
	logic [IDX_W-1:0]      idx;
	logic                  grant;
	logic                  ram_we;
	logic [OWNER_W-1:0]    ram_rdata;
	logic                  rel_hit;

	assign lim    = (cap_q > MAX_CNT) ? MAX_CNT : cap_q;
	assign in_rng = (idx_q < lim);
	assign idx    = idx_q[IDX_W-1:0];
	assign grant  = (cnt_q >= want_q);

	assign ram_we  = ctl.alloc_step && (rem_q != '0) && in_rng && free_q[idx];
	assign rel_hit = rd_vld_s1 && !free_q[rd_idx_s1] && (ram_rdata == owner_q);

	assign sts.scan_end   = !in_rng;
	assign sts.is_rel     = (op_t'(op_q) == OP_RELEASE);
	assign sts.go_alloc   = (op_t'(op_q) == OP_ALLOC) && grant && (want_q != '0);
	assign sts.alloc_done = (rem_q == '0);
	assign sts.rel_done   = !in_rng && !rd_vld_s1;

	assign res_ok   = res_ok_q;
	assign res_free = res_free_q;

	bao_ram #(
		.WIDTH(OWNER_W),
		.DEPTH(MAX_BLOCKS)
	) u_owner_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (idx),
		.wdata (owner_q),
		.raddr (idx),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q     <= MAX_CNT;
			free_q    <= '1;
			rd_vld_s1 <= 1'b0;
		end else begin
			if (cfg_wr_en) cap_q <= cfg_wr_data;
			if (ram_we) free_q[idx] <= 1'b0;
			if (ctl.rel_step && rel_hit) free_q[rd_idx_s1] <= 1'b1;
			rd_vld_s1 <= ctl.rel_step && in_rng;
		end
	end

	always_ff @(posedge clk) begin
		rd_idx_s1 <= idx;
		if (ctl.load) begin
			op_q    <= req_op;
			owner_q <= req_owner;
			want_q  <= req_count;
			idx_q   <= '0;
			cnt_q   <= '0;
			ok_q    <= 1'b0;
		end
		if (ctl.cnt_step && in_rng) begin
			cnt_q <= cnt_q + CNT_W'(free_q[idx]);
			idx_q <= idx_q + CNT_W'(1);
		end
		if (ctl.restart) begin
			idx_q <= '0;
			rem_q <= want_q;
			ok_q  <= (op_t'(op_q) == OP_ALLOC) && grant;
		end
		if (ctl.alloc_step && (rem_q != '0) && in_rng) begin
			idx_q <= idx_q + CNT_W'(1);
			if (free_q[idx]) begin
				rem_q <= rem_q - CNT_W'(1);
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
		if (ctl.rel_step) begin
			if (in_rng) idx_q <= idx_q + CNT_W'(1);
			if (rel_hit) begin
				cnt_q <= cnt_q + CNT_W'(1);
				ok_q  <= 1'b1;
			end
		end
		if (ctl.out_load) begin
			res_ok_q   <= ok_q;
			res_free_q <= cnt_q;
		end
	end

endmodule

>>> rtl/block_owner_allocator.sv
`timescale 1ns / 1ps
// Owner-tagged block allocator over a pool of 64 blocks, of which the lowest
// capacity blocks are in use. A request word is taken only while the block is
// idle; a finished result word sits in an output register, so the next request
// is taken while that word still waits. Every request first counts the free
// blocks with one serial pass over the in-use blocks. An allocate that is
// granted with a nonzero count then walks the blocks again until the count is
// tagged, one block a cycle; a release walks all in-use blocks through the owner
// memory, whose read is registered.
module block_owner_allocator (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [6:0]  cfg_wr_data,  // capacity
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,      // owner_id[7:0], block_count[14:8], zero[15]
	input  logic        s_tuser,      // operation
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata       // success[0], free_blocks[7:1]
);
	import bao_pkg::*;

	bao_ctl_t         ctl;
	bao_sts_t         sts;
	logic             res_ok;
	logic [CNT_W-1:0] res_free;

	bao_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.sts      (sts),
		.ctl      (ctl)
	);

	bao_dpath u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.req_op      (s_tuser),
		.req_owner   (s_tdata[OWNER_W-1:0]),
		.req_count   (s_tdata[OWNER_W+CNT_W-1:OWNER_W]),
		.ctl         (ctl),
		.sts         (sts),
		.res_ok      (res_ok),
		.res_free    (res_free)
	);

	assign m_tdata = {res_free, res_ok};

endmodule

>>> rtl/bao_checker.sv
`timescale 1ns / 1ps
module bao_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       s_tvalid,
	input logic       s_tready,
	input logic       m_tvalid,
	input logic       m_tready,
	input logic [7:0] m_tdata
);

	// A result word that is held back keeps its value.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result word changed while stalled");

	// The free count never exceeds the pool size.
	a_free_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[7:1] <= 7'd64))
		else $error("free count out of range");

	// Once a request is taken the block is busy with it.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("request taken while another is in work");

	// When no result word is waiting, none appears in the cycle after a request is taken.
	a_no_instant: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && !m_tvalid |=> !m_tvalid)
		else $error("result appeared too early");

endmodule

bind block_owner_allocator bao_checker u_bao_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

>>> tb/alloc_grant_monitor.sv
`timescale 1ns / 1ps
module alloc_grant_monitor (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [6:0]  cfg_wr_data,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [15:0] s_tdata,
	input  logic        s_tuser,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [7:0]  m_tdata,
	output int          mismatches,
	output int          outstanding
);
	import bao_pkg::*;

	typedef struct packed {
		logic             success;
		logic [CNT_W-1:0] free_blocks;
	} grant_t;

	logic [MAX_BLOCKS-1:0] free_map;
	logic [OWNER_W-1:0]    owner_of [MAX_BLOCKS];
	logic [CNT_W-1:0]      capacity;
	grant_t                grants_due [$];
	grant_t                due;
	grant_t                got;
	int                    errs;

	function automatic int free_within(int live);
		int n;
		n = 0;
		for (int k = 0; k < live; k++) begin
			if (free_map[k]) begin
				n++;
			end
		end
		return n;
	endfunction

	// Applies one request to the mirrored pool and returns the word it should produce.
	function automatic grant_t grant_request(op_t op, logic [OWNER_W-1:0] owner,
			logic [CNT_W-1:0] want);
		grant_t g;
		int live;
		int left;
		live = (capacity > MAX_BLOCKS) ? MAX_BLOCKS : int'(capacity);
		left = int'(want);
		g.success = 1'b0;
		if (op == OP_ALLOC) begin
			if (free_within(live) >= left) begin
				for (int k = 0; k < live && left > 0; k++) begin
					if (free_map[k]) begin
						free_map[k] = 1'b0;
						owner_of[k] = owner;
						left--;
					end
				end
				g.success = 1'b1;
			end
		end else begin
			// Blocks above the capacity keep their tags and are left alone.
			for (int k = 0; k < live; k++) begin
				if (!free_map[k] && owner_of[k] == owner) begin
					free_map[k] = 1'b1;
					g.success = 1'b1;
				end
			end
		end
		g.free_blocks = CNT_W'(free_within(live));
		return g;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_map = '1;
			for (int k = 0; k < MAX_BLOCKS; k++) begin
				owner_of[k] = '0;
			end
			capacity = MAX_CNT;
			grants_due.delete();
			errs = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				got.success = m_tdata[0];
				got.free_blocks = m_tdata[7:1];
				if (grants_due.size() == 0) begin
					errs++;
					$error("result word with no request waiting: success %0d free_blocks %0d",
						got.success, got.free_blocks);
				end else begin
					due = grants_due.pop_front();
					if (got.success !== due.success) begin
						errs++;
						$error("success: expected %0d, actual %0d", due.success, got.success);
					end
					if (got.free_blocks !== due.free_blocks) begin
						errs++;
						$error("free_blocks: expected %0d, actual %0d",
							due.free_blocks, got.free_blocks);
					end
				end
			end
			if (cfg_wr_en) begin
				capacity = cfg_wr_data;
			end
			if (s_tvalid && s_tready) begin
				grants_due.push_back(grant_request(op_t'(s_tuser), s_tdata[7:0], s_tdata[14:8]));
			end
		end
		mismatches <= errs;
		outstanding <= grants_due.size();
	end

endmodule

>>> tb/block_owner_allocator_tb.sv
`timescale 1ns / 1ps
module block_owner_allocator_tb;
	import bao_pkg::*;

	localparam int PHASES      = 12;
	localparam int PHASE_WORDS = 150;
	localparam int HOLD_CYCLES = 800;
	localparam int TAIL_CYCLES = 2 * MAX_BLOCKS + 16;
	localparam int STALL_LIMIT = 5000;

	logic        clk;
	logic        arst_n;
	logic        cfg_wr_en;
	logic [6:0]  cfg_wr_data;
	logic        s_tvalid;
	logic        s_tready;
	logic [15:0] s_tdata;
	logic        s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [7:0]  m_tdata;

	int mismatches;
	int outstanding;
	int holds_asked;
	int holds_done;
	int stall_cycles;
	bit quiet_tail;

	block_owner_allocator u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata)
	);

	alloc_grant_monitor u_monitor (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	initial begin
		clk = 1'b0;
	end

	always #5 clk = ~clk;

	// Leaves valid high after acceptance; the caller lowers it when a gap follows.
	task automatic send_word(op_t op, logic [OWNER_W-1:0] owner, logic [6:0] want);
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= {1'b0, want, owner};
		@(posedge clk);
		while (!s_tready) begin
			@(posedge clk);
		end
	endtask

	task automatic pause_sender(int cycles);
		s_tvalid <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	// Capacity only changes once every result word is back and the block is idle.
	task automatic set_capacity(logic [6:0] cap);
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) begin
			@(posedge clk);
		end
		repeat (4) @(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= cap;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		@(posedge clk);
	endtask

	initial begin : receiver
		m_tready = 1'b0;
		holds_done = 0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			m_tready <= 1'b1;
			repeat ($urandom_range(1, 40)) @(posedge clk);
			if (holds_done < holds_asked) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				holds_done++;
			end else if (!quiet_tail && $urandom_range(0, 1) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 18)) @(posedge clk);
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || cfg_wr_en || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= STALL_LIMIT) begin
			$display("block_owner_allocator_tb: done, errors");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	initial begin : stimulus
		logic [OWNER_W-1:0] crowd [8];
		logic [6:0]         cap;
		logic [OWNER_W-1:0] owner;
		logic [6:0]         want;
		op_t                op;
		int                 live;
		int                 pick;
		bit                 gappy;

		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = 1'b0;
		holds_asked = 0;
		quiet_tail = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part: empty and oversized requests, a full pool, releases that miss,
		// and tagged blocks stranded above a lowered capacity.
		set_capacity(7'd64);
		send_word(OP_ALLOC, 8'h00, 7'd0);
		send_word(OP_ALLOC, 8'hFF, 7'd127);
		send_word(OP_ALLOC, 8'h01, 7'd65);
		send_word(OP_ALLOC, 8'hFF, 7'd64);
		send_word(OP_ALLOC, 8'h00, 7'd1);
		send_word(OP_RELEASE, 8'h00, 7'd127);
		send_word(OP_RELEASE, 8'hFF, 7'd0);
		send_word(OP_ALLOC, 8'hAA, 7'd5);
		send_word(OP_ALLOC, 8'h55, 7'd3);
		send_word(OP_ALLOC, 8'hAA, 7'd2);
		send_word(OP_RELEASE, 8'hAA, 7'd64);
		set_capacity(7'd4);
		send_word(OP_RELEASE, 8'h55, 7'd0);
		send_word(OP_ALLOC, 8'h0F, 7'd4);
		send_word(OP_ALLOC, 8'h0F, 7'd1);
		set_capacity(7'd0);
		send_word(OP_ALLOC, 8'h0F, 7'd1);
		send_word(OP_ALLOC, 8'h0F, 7'd0);
		send_word(OP_RELEASE, 8'h0F, 7'd0);
		set_capacity(7'd127);
		send_word(OP_RELEASE, 8'h55, 7'd0);
		send_word(OP_RELEASE, 8'h0F, 7'd0);
		send_word(OP_ALLOC, 8'h80, 7'd64);
		send_word(OP_RELEASE, 8'h80, 7'd0);

		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0:       cap = 7'd64;
				1:       cap = 7'd1;
				2:       cap = 7'd127;
				3:       cap = 7'd0;
				4:       cap = 7'd17;
				5:       cap = 7'd2;
				6:       cap = 7'($urandom_range(1, 64));
				7:       cap = 7'd40;
				8:       cap = 7'($urandom_range(0, 127));
				9:       cap = 7'd63;
				default: cap = 7'd64;
			endcase
			set_capacity(cap);
			live = (cap > MAX_BLOCKS) ? MAX_BLOCKS : int'(cap);
			for (int k = 0; k < 8; k++) begin
				crowd[k] = 8'($urandom_range(0, 255));
			end
			quiet_tail = (p == PHASES - 1);
			gappy = (p != 0) && !quiet_tail && ($urandom_range(0, 2) != 0);
			// The first phase keeps offering words while the result side holds off.
			if (p == 0) begin
				holds_asked++;
			end
			for (int n = 0; n < PHASE_WORDS; n++) begin
				pick = $urandom_range(0, 99);
				want = 7'($urandom_range(0, 127));
				if (pick < 50) begin
					op = OP_ALLOC;
					owner = crowd[$urandom_range(0, 7)];
					want = ($urandom_range(0, 3) == 0) ? 7'($urandom_range(0, live)) :
						7'($urandom_range(0, 6));
				end else if (pick < 85) begin
					op = OP_RELEASE;
					owner = crowd[$urandom_range(0, 7)];
				end else if (pick < 92) begin
					op = OP_ALLOC;
					owner = 8'($urandom_range(0, 255));
				end else begin
					op = OP_RELEASE;
					owner = 8'($urandom_range(0, 255));
				end
				send_word(op, owner, want);
				if (gappy && $urandom_range(0, 3) == 0) begin
					pause_sender($urandom_range(1, 18));
				end
			end
		end

		s_tvalid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) begin
			@(posedge clk);
		end
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0 && outstanding == 0) begin
			$display("block_owner_allocator_tb: done, clean");
		end else begin
			$display("block_owner_allocator_tb: done, errors");
		end
		$finish;
	end

endmodule

>>> files.f
rtl/bao_pkg.sv
rtl/bao_ram.sv
rtl/bao_ctrl.sv
rtl/bao_dpath.sv
rtl/block_owner_allocator.sv
rtl/bao_checker.sv
tb/alloc_grant_monitor.sv
tb/block_owner_allocator_tb.sv
